/* design/sha256_stream_hasher_defines.svh */
// assertion macros for the sha256 stream hasher top level
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, checked on i_clk, quiet while in reset
`define SHA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk, quiet while in reset
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sha_pkg.sv */
// shared types for the sha256 stream hasher
package sha_pkg;

    typedef logic [31:0] t_word;
    typedef t_word t_chain [8];
    typedef t_word t_block [16];

    // commands from the sequencer to the round engine
    typedef struct packed {
        logic start;
        logic init;
    } t_core_ctl;

    // status back from the round engine
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

endpackage

/* design/sha_in_if.sv */
// input channel: one message byte beat with end flag
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;

    modport source (output valid, output data_byte, output byte_present,
                    output message_end, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input message_end, output ready);
endinterface

/* design/sha_out_if.sv */
// output channel: one digest word beat
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

/* design/sha_core.sv */
// sha256 round engine: one round per cycle, chaining words held here
module sha_core
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    input  t_block    i_block,
    output t_core_sts o_sts,
    output t_chain    o_chain
);

    localparam t_chain H_INIT = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_ADD
    } t_state;

    function automatic t_word f_rotr(t_word x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word f_bsig0(t_word x);
        return f_rotr(x, 2) ^ f_rotr(x, 13) ^ f_rotr(x, 22);
    endfunction

    function automatic t_word f_bsig1(t_word x);
        return f_rotr(x, 6) ^ f_rotr(x, 11) ^ f_rotr(x, 25);
    endfunction

    function automatic t_word f_ssig0(t_word x);
        return f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word f_ssig1(t_word x);
        return f_rotr(x, 17) ^ f_rotr(x, 19) ^ (x >> 10);
    endfunction

    t_state     r_state;
    logic [5:0] r_round;
    logic       r_done;
    t_block     r_w;
    t_chain     r_v;
    t_chain     r_chain;

    t_word w_t1;
    t_word w_t2;
    t_word w_wnew;

    // round datapath; r_w[0] is always the current schedule word
    always_comb begin
        w_t1 = r_v[7] + f_bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + ROUND_K[r_round] + r_w[0];
        w_t2 = f_bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_wnew = f_ssig1(r_w[14]) + r_w[9] + f_ssig0(r_w[1]) + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
            r_chain <= H_INIT;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.init) begin
                r_chain <= H_INIT;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_w     <= i_block;
                        r_v     <= r_chain;
                        r_round <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    // sliding schedule window
                    for (int j = 0; j < 15; j++) begin
                        r_w[j] <= r_w[j + 1];
                    end
                    r_w[15] <= w_wnew;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int j = 0; j < 8; j++) begin
                        r_chain[j] <= r_chain[j] + r_v[j];
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = r_done;
    assign o_chain    = r_chain;

endmodule

/* design/sha256_stream_hasher.sv */
// top level of the sha256 stream hasher: byte packing, padding sequencer, digest output
//
// i_in carries one beat per message item: data_byte, a byte_present flag and a
// message_end flag. o_out carries the digest as eight beats, word_index 0 first,
// last_word high on the eighth.
// a beat that neither fills a block nor ends the message leaves ready high. the
// beat that completes a 64-byte block holds ready low through a start step, 64
// rounds one per cycle, a chaining-add step and a step to hand completion back.
// at message end: a padding step, one pass like the above per final block, a
// length setup before a second final block (needed when fewer than 9 bytes are
// free), and a step to latch the digest.
// the digest sits in its own register, so new message beats are taken while the
// eight words drain; a second message end waits until the previous digest is gone.
// a receiver stall just holds the current digest word.
// reset (synchronous, active low) loads the initial hash values, clears the block
// buffer and byte counter, and drops o_out.valid.
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_OFF = 6'd63;
    localparam logic [5:0] LEN_ROOM = 6'd55;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PAD,
        S_LEN,
        S_FINAL
    } t_state;

    // where the sequencer goes when the round engine finishes
    typedef enum logic [1:0] {
        A_IDLE,
        A_PAD,
        A_LEN,
        A_FINAL
    } t_after;

    t_state      r_state;
    t_after      r_after;
    logic [60:0] r_count;
    t_block      r_block;
    logic        r_start;
    logic        r_init;
    t_chain      r_dig;
    logic        r_emit_on;
    logic [2:0]  r_emit_idx;

    t_core_ctl   w_ctl;
    t_core_sts   w_sts;
    t_chain      w_chain;
    t_block      w_pad;
    t_block      w_len_blk;
    logic        w_in_acc;
    logic [5:0]  w_off;
    logic [4:0]  w_sh;
    t_word       w_len_hi;
    t_word       w_len_lo;

    assign w_ctl.start = r_start;
    assign w_ctl.init  = r_init;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_block (r_block),
        .o_sts   (w_sts),
        .o_chain (w_chain)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;

    // next byte slot in the block, big-endian inside each word
    assign w_off = r_count[5:0];
    assign w_sh  = {~w_off[1:0], 3'b000};

    // message bit length is byte count times eight
    assign w_len_hi = r_count[60:29];
    assign w_len_lo = {r_count[28:0], 3'b000};

    // pad marker at the next slot, zeros behind it, message bytes kept ahead of it,
    // and the length in the last two words when it fits
    always_comb begin
        w_pad = r_block;
        for (int j = 0; j < 64; j++) begin
            if (6'(j) == w_off) begin
                w_pad[j / 4][(3 - (j % 4)) * 8 +: 8] = PAD_BYTE;
            end else if (6'(j) > w_off) begin
                w_pad[j / 4][(3 - (j % 4)) * 8 +: 8] = 8'h00;
            end
        end
        if (w_off <= LEN_ROOM) begin
            w_pad[14] = w_len_hi;
            w_pad[15] = w_len_lo;
        end
    end

    // extra block for a length that did not fit: all zeros but the length
    always_comb begin
        w_len_blk     = '{default: '0};
        w_len_blk[14] = w_len_hi;
        w_len_blk[15] = w_len_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_after    <= A_IDLE;
            r_count    <= '0;
            r_block    <= '{default: '0};
            r_start    <= 1'b0;
            r_init     <= 1'b0;
            r_emit_on  <= 1'b0;
            r_emit_idx <= '0;
        end else begin
            r_start <= 1'b0;
            r_init  <= 1'b0;

            // digest drain
            if (o_out.valid && o_out.ready) begin
                r_emit_idx <= r_emit_idx + 3'd1;
                if (r_emit_idx == 3'd7) begin
                    r_emit_on <= 1'b0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.byte_present) begin
                            r_block[w_off[5:2]][w_sh +: 8] <= i_in.data_byte;
                            r_count <= r_count + 61'd1;
                        end
                        if (i_in.byte_present && w_off == LAST_OFF) begin
                            // block full: compress, then pad if the message ends here
                            r_start <= 1'b1;
                            r_state <= S_HASH;
                            r_after <= i_in.message_end ? A_PAD : A_IDLE;
                        end else if (i_in.message_end) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_block <= w_pad;
                    r_start <= 1'b1;
                    r_state <= S_HASH;
                    if (w_off > LEN_ROOM) begin
                        // no room for the length: it goes in an extra block
                        r_after <= A_LEN;
                    end else begin
                        r_after <= A_FINAL;
                    end
                end
                S_LEN: begin
                    r_block <= w_len_blk;
                    r_start <= 1'b1;
                    r_after <= A_FINAL;
                    r_state <= S_HASH;
                end
                S_HASH: begin
                    if (w_sts.done) begin
                        unique case (r_after)
                            A_IDLE:  r_state <= S_IDLE;
                            A_PAD:   r_state <= S_PAD;
                            A_LEN:   r_state <= S_LEN;
                            A_FINAL: r_state <= S_FINAL;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FINAL: begin
                    // wait for the previous digest to drain, then latch and restart
                    if (!r_emit_on) begin
                        r_dig      <= w_chain;
                        r_emit_on  <= 1'b1;
                        r_emit_idx <= '0;
                        r_init     <= 1'b1;
                        r_block    <= '{default: '0};
                        r_count    <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_emit_on;
    assign o_out.digest_word = r_dig[r_emit_idx];
    assign o_out.word_index  = r_emit_idx;
    assign o_out.last_word   = (r_emit_idx == 3'd7);

    // taking beats only while the round engine is quiet
    `SHA_ASSERT_SAME(a_ready_engine_idle, i_in.ready, (!w_sts.busy && !r_start), "ready while engine active")
    // engine never restarted mid-block
    `SHA_ASSERT_SAME(a_start_when_idle, r_start, !w_sts.busy, "engine start while busy")
    // completion only expected while the sequencer waits for it
    `SHA_ASSERT_SAME(a_done_in_hash, w_sts.done, (r_state == S_HASH), "engine done outside hash wait")
    // digest latch starts a fresh drain and clears the byte count
    `SHA_ASSERT_NEXT(a_final_latch, (r_state == S_FINAL && !r_emit_on), (r_emit_on && r_emit_idx == 3'd0 && r_count == 61'd0), "digest latch failed")

endmodule
